// ----- rtl/ascs_pkg.sv -----
// Shared types, constants and helpers of the servo command slewer.
package ascs_pkg;

   localparam int LINE_LEN   = 4;
   localparam int LEN_W      = $clog2(LINE_LEN + 1);
   localparam int IDX_W      = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
   localparam int NUM_JOINTS = 6;
   localparam int VAL_SAT    = 100000;
   localparam int MAG_W      = $clog2(VAL_SAT + 1);
   localparam int DATA_W     = 64;

   localparam logic [7:0] CHAR_TAB    = 8'd9;
   localparam logic [7:0] CHAR_LF     = 8'd10;
   localparam logic [7:0] CHAR_CR     = 8'd13;
   localparam logic [7:0] CHAR_SPACE  = 8'd32;
   localparam logic [7:0] CHAR_PLUS   = 8'd43;
   localparam logic [7:0] CHAR_MINUS  = 8'd45;
   localparam logic [7:0] CHAR_ZERO   = 8'd48;
   localparam logic [7:0] CHAR_NINE   = 8'd57;
   localparam logic [7:0] CHAR_UP_A   = 8'd65;
   localparam logic [7:0] CHAR_UP_F   = 8'd70;
   localparam logic [7:0] CHAR_LOW_A  = 8'd97;
   localparam logic [7:0] CHAR_LOW_Z  = 8'd122;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   localparam logic REG_STEP_PERIOD = 1'b0;
   localparam logic REG_MAX_ANGLE   = 1'b1;

   localparam logic [9:0] STEP_PERIOD_RESET = 10'd10;
   localparam logic [7:0] MAX_ANGLE_RESET   = 8'd180;

   typedef logic [LINE_LEN-1:0][7:0]   line_type;
   typedef logic [NUM_JOINTS-1:0][7:0] angles_type;

   typedef struct packed {
      logic [2:0] joint;
      logic [7:0] angle;
   } cmd_type;

   localparam angles_type HOME_POSE = {8'd55, 8'd105, 8'd105, 8'd90, 8'd90, 8'd90};

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

endpackage

// ----- rtl/ascs_parser.sv -----
// Command line parser: joint letter plus signed decimal, clamped to the max angle.
module ascs_parser (
   input  ascs_pkg::line_type           line,
   input  logic [ascs_pkg::LEN_W-1:0]   len,
   input  logic [7:0]                   max_angle,
   output ascs_pkg::cmd_type            cmd
);

   typedef enum logic [3:0] {
      PH_LEAD = 4'b0001,
      PH_POST = 4'b0010,
      PH_DIG  = 4'b0100,
      PH_DONE = 4'b1000
   } phase_type;

   always_comb begin
      phase_type                   ph;
      logic [7:0]                  jl;
      logic                        neg;
      logic [ascs_pkg::MAG_W-1:0]  mag;
      logic [ascs_pkg::MAG_W+3:0]  acc;
      logic [7:0]                  c;
      logic [7:0]                  up;
      ph  = PH_LEAD;
      jl  = '0;
      neg = 1'b0;
      mag = '0;
      acc = '0;
      up  = '0;
      for (int k = 0; k < ascs_pkg::LINE_LEN; k++) begin
         c = line[k];
         if (k < int'(len)) begin
            case (ph)
               PH_LEAD: begin
                  if (!ascs_pkg::is_ws(c)) begin
                     jl = c;
                     ph = PH_POST;
                  end
               end
               PH_POST: begin
                  if (ascs_pkg::is_ws(c)) begin
                     ph = PH_POST;
                  end else if (c == ascs_pkg::CHAR_MINUS || c == ascs_pkg::CHAR_PLUS) begin
                     neg = (c == ascs_pkg::CHAR_MINUS);
                     ph  = PH_DIG;
                  end else if (ascs_pkg::is_digit(c)) begin
                     mag = ascs_pkg::MAG_W'(c - ascs_pkg::CHAR_ZERO);
                     ph  = PH_DIG;
                  end else begin
                     ph = PH_DONE;
                  end
               end
               PH_DIG: begin
                  if (ascs_pkg::is_digit(c)) begin
                     acc = ({4'b0, mag} << 3) + ({4'b0, mag} << 1)
                         + (ascs_pkg::MAG_W + 4)'(c - ascs_pkg::CHAR_ZERO);
                     if (acc > (ascs_pkg::MAG_W + 4)'(ascs_pkg::VAL_SAT))
                        mag = ascs_pkg::MAG_W'(ascs_pkg::VAL_SAT);
                     else
                        mag = acc[ascs_pkg::MAG_W-1:0];
                  end else begin
                     ph = PH_DONE;
                  end
               end
               default: begin
                  ph = PH_DONE;
               end
            endcase
         end
      end

      if (jl >= ascs_pkg::CHAR_LOW_A && jl <= ascs_pkg::CHAR_LOW_Z)
         up = jl - ascs_pkg::CASE_OFFSET;
      else
         up = jl;

      cmd = '0;
      if (ph != PH_LEAD && up >= ascs_pkg::CHAR_UP_A && up <= ascs_pkg::CHAR_UP_F) begin
         cmd.joint = 3'(up - ascs_pkg::CHAR_UP_A + 8'd1);
         if (neg)
            cmd.angle = '0;
         else if (mag > ascs_pkg::MAG_W'(max_angle))
            cmd.angle = max_angle;
         else
            cmd.angle = mag[7:0];
      end
   end

endmodule

// ----- rtl/ascii_servo_command_slewer.sv -----
// Servo command slewer top level: line buffer, joint targets and slew stepping.
//
// Each item is a serial byte (req_tuser = 0) or a 1 ms tick (req_tuser = 1) and yields
// exactly one result item carrying the six joint angles after that item, the moving
// flag and the command accepted by it, if any. Bytes other than CR/LF fill a
// four-byte line; CR, LF or a full line parses it as a joint letter A-F plus a signed
// decimal clamped to 0..max_angle. Every step_period_ticks ticks all joints move one
// degree toward their targets at once. An item is registered on entry, then parsed and
// applied once the result register is free and lands in the result register; one item
// is taken every cycle while the result is not stalled, and the parse of the line
// register feeding the target update is combinational. csr_ready is always high; the user
// must write registers only while the block is idle, which the block does not enforce.
module ascii_servo_command_slewer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // angle_a, angle_b, angle_c, angle_d, angle_e, angle_f, moving, cmd_joint, cmd_angle, pad
   output logic [63:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [9:0]  csr_data
);

   logic                          in_valid_ff, in_valid_in;
   logic                          in_action_ff;
   logic [7:0]                    in_byte_ff;
   logic                          out_valid_ff, out_valid_in;
   logic [ascs_pkg::DATA_W-1:0]   out_data_ff, out_data_in;
   logic [7:0]                    line_buf_ff [ascs_pkg::LINE_LEN];
   logic [ascs_pkg::LEN_W-1:0]    line_len_ff, line_len_in;
   ascs_pkg::angles_type          angle_ff, angle_in;
   ascs_pkg::angles_type          target_ff, target_in;
   logic [9:0]                    tick_ff, tick_in;
   logic [9:0]                    period_ff;
   logic [7:0]                    max_angle_ff;

   logic                          advance;
   logic                          is_byte;
   logic                          eol;
   logic                          append;
   logic                          flush;
   logic                          cmd_fire;
   logic                          step;
   logic                          moving;
   logic [ascs_pkg::LEN_W-1:0]    len_after;
   ascs_pkg::line_type            cur_line;
   ascs_pkg::cmd_type             cmd;
   ascs_pkg::cmd_type             cmd_out;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_tready);

   assign is_byte   = (in_action_ff == ascs_pkg::ACT_BYTE);
   assign eol       = (in_byte_ff == ascs_pkg::CHAR_LF) || (in_byte_ff == ascs_pkg::CHAR_CR);
   assign append    = is_byte && !eol && (line_len_ff < ascs_pkg::LEN_W'(ascs_pkg::LINE_LEN));
   assign len_after = append ? line_len_ff + 1'b1 : line_len_ff;
   assign flush     = is_byte && (eol || len_after >= ascs_pkg::LEN_W'(ascs_pkg::LINE_LEN));
   assign cmd_fire  = flush && (len_after >= ascs_pkg::LEN_W'(2)) && (cmd.joint != 3'd0);
   assign step      = !is_byte && (({1'b0, tick_ff} + 11'd1) >= {1'b0, period_ff});

   always_comb begin
      for (int k = 0; k < ascs_pkg::LINE_LEN; k++) begin
         if (append && (k == int'(line_len_ff)))
            cur_line[k] = in_byte_ff;
         else
            cur_line[k] = line_buf_ff[k];
      end
   end

   ascs_parser u_parser (
      .line      (cur_line),
      .len       (len_after),
      .max_angle (max_angle_ff),
      .cmd       (cmd)
   );

   always_comb begin
      line_len_in = line_len_ff;
      tick_in     = tick_ff;
      target_in   = target_ff;
      angle_in    = angle_ff;
      if (advance) begin
         if (is_byte) begin
            line_len_in = flush ? '0 : len_after;
            for (int j = 0; j < ascs_pkg::NUM_JOINTS; j++) begin
               if (cmd_fire && (cmd.joint == 3'(j + 1)))
                  target_in[j] = cmd.angle;
            end
         end else if (step) begin
            tick_in = '0;
            for (int j = 0; j < ascs_pkg::NUM_JOINTS; j++) begin
               if (angle_ff[j] < target_ff[j])
                  angle_in[j] = angle_ff[j] + 8'd1;
               else if (angle_ff[j] > target_ff[j])
                  angle_in[j] = angle_ff[j] - 8'd1;
            end
         end else begin
            tick_in = tick_ff + 10'd1;
         end
      end
   end

   always_comb begin
      moving = 1'b0;
      for (int j = 0; j < ascs_pkg::NUM_JOINTS; j++) begin
         if (angle_in[j] != target_in[j])
            moving = 1'b1;
      end
      cmd_out     = cmd_fire ? cmd : '0;
      out_data_in = {4'b0, cmd_out.angle, cmd_out.joint, moving, angle_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         line_len_ff  <= '0;
         tick_ff      <= '0;
         angle_ff     <= ascs_pkg::HOME_POSE;
         target_ff    <= ascs_pkg::HOME_POSE;
         period_ff    <= ascs_pkg::STEP_PERIOD_RESET;
         max_angle_ff <= ascs_pkg::MAX_ANGLE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         line_len_ff  <= line_len_in;
         tick_ff      <= tick_in;
         angle_ff     <= angle_in;
         target_ff    <= target_in;
         if (csr_valid && (csr_index == ascs_pkg::REG_STEP_PERIOD))
            period_ff <= csr_data;
         if (csr_valid && (csr_index == ascs_pkg::REG_MAX_ANGLE))
            max_angle_ff <= csr_data[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_action_ff <= req_tuser;
         in_byte_ff   <= req_tdata;
      end
      if (advance)
         out_data_ff <= out_data_in;
      if (advance && append)
         line_buf_ff[line_len_ff[ascs_pkg::IDX_W-1:0]] <= in_byte_ff;
   end

endmodule

// ----- rtl/ascs_checker.sv -----
// Port-level assertions for the servo command slewer, bound to the top level.
module ascs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic        csr_index,
   input logic [9:0]  csr_data
);

   logic                 prev_valid_ff;
   ascs_pkg::angles_type prev_angle_ff;
   ascs_pkg::angles_type cur_angle;
   logic                 slew_ok;
   logic                 unused_in;

   assign cur_angle = rsp_tdata[47:0];
   assign unused_in = ^{req_tvalid, req_tready, req_tdata, req_tuser,
                        csr_valid, csr_ready, csr_index, csr_data};

   always_comb begin
      slew_ok = 1'b1;
      for (int j = 0; j < ascs_pkg::NUM_JOINTS; j++) begin
         if ((cur_angle[j] != prev_angle_ff[j]) &&
             (cur_angle[j] != prev_angle_ff[j] + 8'd1) &&
             (cur_angle[j] != prev_angle_ff[j] - 8'd1))
            slew_ok = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         prev_valid_ff <= 1'b1;
      end
      if (rsp_tvalid && rsp_tready)
         prev_angle_ff <= cur_angle;
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_cmd_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[51:49] <= 3'd6) &&
                     ((rsp_tdata[51:49] != 3'd0) || (rsp_tdata[59:52] == 8'd0)) &&
                     (rsp_tdata[63:60] == 4'd0) && (unused_in == unused_in))
      else $error("bad command fields");

   a_slew_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && prev_valid_ff |-> slew_ok)
      else $error("joint moved more than one degree between results");

endmodule

bind ascii_servo_command_slewer ascs_checker u_ascs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready),
   .csr_index  (csr_index),
   .csr_data   (csr_data)
);

// ----- test/ascii_servo_command_slewer_tb.sv -----
// Testbench for the servo command slewer: directed lines, random command streams, predictor check.
`timescale 1ns / 1ps

module ascii_servo_command_slewer_tb;

   localparam int LIMIT_CYCLES = 400000;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 130;
   localparam int DIRECTED_N   = 24;

   typedef struct packed {
      logic       act;
      logic [7:0] data;
      logic       known;
      logic [2:0] joint;
      logic [7:0] angle;
   } stim_type;

   typedef struct packed {
      logic [7:0]           cmd_angle;
      logic [2:0]           cmd_joint;
      logic                 moving;
      ascs_pkg::angles_type angles;
   } servo_state_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // rx_byte
   logic        req_tuser  = 1'b0;   // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // angle_a, angle_b, angle_c, angle_d, angle_e, angle_f, moving, cmd_joint, cmd_angle, pad
   logic [63:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = 1'b0;
   logic [9:0]  csr_data   = 10'd0;

   // typed-in command fields that ride along with a directed item
   logic        req_known  = 1'b0;
   logic [2:0]  req_joint  = 3'd0;
   logic [7:0]  req_angle  = 8'd0;

   // predictor state
   logic [7:0]           line_bytes [ascs_pkg::LINE_LEN];
   int                   line_fill    = 0;
   ascs_pkg::angles_type joint_pos    = ascs_pkg::HOME_POSE;
   ascs_pkg::angles_type joint_goal   = ascs_pkg::HOME_POSE;
   int                   ticks_seen   = 0;
   int                   step_period  = int'(ascs_pkg::STEP_PERIOD_RESET);
   int                   clamp_limit  = int'(ascs_pkg::MAX_ANGLE_RESET);

   servo_state_type predicted_poses [$];
   stim_type        input_backlog [$];
   stim_type        directed_rows [DIRECTED_N];
   servo_state_type want, got;

   int mismatch_count = 0;
   int cycle_count    = 0;
   int items_taken    = 0;
   int cmds_taken     = 0;
   int slew_steps     = 0;
   int csr_writes     = 0;
   int burst_left     = 0;
   int stall_left     = 0;
   int stall_mode     = 0;
   int stall_phase    = 0;
   int period_plan [PHASES];
   int limit_plan  [PHASES];

   ascii_servo_command_slewer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic blank_char(input logic [7:0] c);
      return (c == ascs_pkg::CHAR_SPACE) ||
             (c >= ascs_pkg::CHAR_TAB && c <= ascs_pkg::CHAR_CR);
   endfunction

   function automatic logic digit_char(input logic [7:0] c);
      return (c >= ascs_pkg::CHAR_ZERO) && (c <= ascs_pkg::CHAR_NINE);
   endfunction

   function automatic servo_state_type advance_slewer(input logic act, input logic [7:0] b);
      servo_state_type r;
      logic            eol;
      logic [7:0]      letter;
      logic            neg;
      int              i, n, mag, v;
      r = '0;
      if (act == ascs_pkg::ACT_BYTE) begin
         eol = (b == ascs_pkg::CHAR_LF) || (b == ascs_pkg::CHAR_CR);
         if (!eol && line_fill < ascs_pkg::LINE_LEN) begin
            line_bytes[line_fill] = b;
            line_fill++;
         end
         if (eol || line_fill >= ascs_pkg::LINE_LEN) begin
            if (line_fill >= 2) begin
               n = line_fill;
               i = 0;
               while (i < n && blank_char(line_bytes[i])) i++;
               if (i < n) begin
                  letter = line_bytes[i];
                  if (letter >= ascs_pkg::CHAR_LOW_A && letter <= ascs_pkg::CHAR_LOW_Z)
                     letter -= ascs_pkg::CASE_OFFSET;
                  i++;
                  while (i < n && blank_char(line_bytes[i])) i++;
                  neg = 1'b0;
                  if (i < n && (line_bytes[i] == ascs_pkg::CHAR_MINUS ||
                                line_bytes[i] == ascs_pkg::CHAR_PLUS)) begin
                     neg = (line_bytes[i] == ascs_pkg::CHAR_MINUS);
                     i++;
                  end
                  mag = 0;
                  while (i < n && digit_char(line_bytes[i])) begin
                     mag = mag * 10 + int'(line_bytes[i]) - int'(ascs_pkg::CHAR_ZERO);
                     if (mag > ascs_pkg::VAL_SAT) mag = ascs_pkg::VAL_SAT;
                     i++;
                  end
                  if (letter >= ascs_pkg::CHAR_UP_A && letter <= ascs_pkg::CHAR_UP_F) begin
                     v = neg ? 0 : mag;
                     if (v > clamp_limit) v = clamp_limit;
                     joint_goal[letter - ascs_pkg::CHAR_UP_A] = 8'(v);
                     r.cmd_joint = 3'(letter - ascs_pkg::CHAR_UP_A + 8'd1);
                     r.cmd_angle = 8'(v);
                     cmds_taken++;
                  end
               end
            end
            line_fill = 0;
         end
      end else if (ticks_seen + 1 >= step_period) begin
         ticks_seen = 0;
         slew_steps++;
         for (int k = 0; k < ascs_pkg::NUM_JOINTS; k++) begin
            if (joint_pos[k] < joint_goal[k]) joint_pos[k]++;
            else if (joint_pos[k] > joint_goal[k]) joint_pos[k]--;
         end
      end else begin
         ticks_seen = (ticks_seen + 1) & 10'h3FF;
      end
      r.angles = joint_pos;
      r.moving = (joint_pos != joint_goal);
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input int got_v, input int want_v);
      mismatch_count++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
   endtask

   // item bookkeeping: prediction on entry, comparison on exit
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want = advance_slewer(req_tuser, req_tdata);
            if (req_known) begin
               want.cmd_joint = req_joint;
               want.cmd_angle = req_angle;
            end
            predicted_poses.push_back(want);
            items_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.angles    = rsp_tdata[47:0];
            got.moving    = rsp_tdata[48];
            got.cmd_joint = rsp_tdata[51:49];
            got.cmd_angle = rsp_tdata[59:52];
            if (predicted_poses.size() == 0) begin
               flag_mismatch("result item with none pending", 1, 0);
            end else begin
               want = predicted_poses.pop_front();
               for (int k = 0; k < ascs_pkg::NUM_JOINTS; k++)
                  if (got.angles[k] != want.angles[k])
                     flag_mismatch($sformatf("angle %0d", k), int'(got.angles[k]),
                                   int'(want.angles[k]));
               if (got.moving != want.moving)
                  flag_mismatch("moving", int'(got.moving), int'(want.moving));
               if (got.cmd_joint != want.cmd_joint)
                  flag_mismatch("cmd_joint", int'(got.cmd_joint), int'(want.cmd_joint));
               if (got.cmd_angle != want.cmd_angle)
                  flag_mismatch("cmd_angle", int'(got.cmd_angle), int'(want.cmd_angle));
            end
         end
      end
   end

   // receiver back-pressure: modes of random length
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         2: begin
            rsp_tready <= (stall_phase % 5) != 0;
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 1) != 0);
         end
      endcase
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d items still pending",
                  cycle_count, predicted_poses.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic drive_item(input stim_type s);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= s.act;
      req_tdata  <= s.data;
      req_known  <= s.known;
      req_joint  <= s.joint;
      req_angle  <= s.angle;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic run_backlog();
      while (input_backlog.size() != 0) drive_item(input_backlog.pop_front());
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (predicted_poses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [9:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == ascs_pkg::REG_STEP_PERIOD) step_period = int'(val);
      else clamp_limit = int'(val[7:0]);
      csr_writes++;
   endtask

   task automatic push_byte(input logic [7:0] b);
      input_backlog.push_back(stim_type'{ascs_pkg::ACT_BYTE, b, 1'b0, 3'd0, 8'd0});
   endtask

   // one command line with random content, sometimes left unterminated
   task automatic queue_command();
      logic [7:0] line_q [$];
      int         r;
      if ($urandom_range(0, 5) == 0)
         line_q.push_back($urandom_range(0, 1) ? ascs_pkg::CHAR_SPACE : ascs_pkg::CHAR_TAB);
      r = $urandom_range(0, 9);
      if (r < 4) line_q.push_back(8'(ascs_pkg::CHAR_UP_A + $urandom_range(0, 5)));
      else if (r < 8) line_q.push_back(8'(ascs_pkg::CHAR_LOW_A + $urandom_range(0, 5)));
      else line_q.push_back(8'($urandom_range(33, 126)));
      if (line_q.size() < ascs_pkg::LINE_LEN && $urandom_range(0, 4) == 0)
         line_q.push_back(ascs_pkg::CHAR_SPACE);
      if (line_q.size() < ascs_pkg::LINE_LEN && $urandom_range(0, 3) == 0)
         line_q.push_back($urandom_range(0, 1) ? ascs_pkg::CHAR_MINUS : ascs_pkg::CHAR_PLUS);
      while (line_q.size() < ascs_pkg::LINE_LEN && $urandom_range(0, 4) != 0)
         line_q.push_back(8'(ascs_pkg::CHAR_ZERO + $urandom_range(0, 9)));
      if (line_q.size() < ascs_pkg::LINE_LEN && $urandom_range(0, 11) != 0)
         line_q.push_back($urandom_range(0, 1) ? ascs_pkg::CHAR_CR : ascs_pkg::CHAR_LF);
      foreach (line_q[k]) push_byte(line_q[k]);
   endtask

   initial begin
      int ticks;
      for (int k = 0; k < ascs_pkg::LINE_LEN; k++) line_bytes[k] = 8'd0;
      directed_rows = '{
         '{ascs_pkg::ACT_BYTE, "A",                  1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_BYTE, "1",                  1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_BYTE, "8",                  1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_BYTE, "0",                  1'b1, 3'd1, 8'd180},
         '{ascs_pkg::ACT_BYTE, "b",                  1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_BYTE, "-",                  1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_BYTE, "5",                  1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_BYTE, ascs_pkg::CHAR_LF,    1'b1, 3'd2, 8'd0},
         '{ascs_pkg::ACT_BYTE, "F",                  1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_BYTE, "9",                  1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_BYTE, "9",                  1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_BYTE, "9",                  1'b1, 3'd6, 8'd180},
         '{ascs_pkg::ACT_BYTE, "Z",                  1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_BYTE, "1",                  1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_BYTE, "2",                  1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_BYTE, ascs_pkg::CHAR_CR,    1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_BYTE, ascs_pkg::CHAR_SPACE, 1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_BYTE, ascs_pkg::CHAR_TAB,   1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_BYTE, ascs_pkg::CHAR_CR,    1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_BYTE, "x",                  1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_BYTE, ascs_pkg::CHAR_LF,    1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_TICK, 8'hFF,                1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_TICK, 8'h00,                1'b1, 3'd0, 8'd0},
         '{ascs_pkg::ACT_TICK, 8'h5A,                1'b1, 3'd0, 8'd0}
      };
      period_plan = '{1, 0, 3, 1023, 2, $urandom_range(1, 1000), 1, $urandom_range(1, 6), 4, 1};
      limit_plan  = '{255, 0, 180, 90, 255, $urandom_range(0, 255), 60,
                      $urandom_range(0, 255), 200, 180};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) input_backlog.push_back(directed_rows[k]);
      run_backlog();

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         if (p % 2 == 0) begin
            write_csr(ascs_pkg::REG_STEP_PERIOD, 10'(period_plan[p]));
            write_csr(ascs_pkg::REG_MAX_ANGLE, 10'(limit_plan[p]));
         end else begin
            write_csr(ascs_pkg::REG_MAX_ANGLE, 10'(limit_plan[p]));
            write_csr(ascs_pkg::REG_STEP_PERIOD, 10'(period_plan[p]));
         end
         csr_valid <= 1'b0;
         while (input_backlog.size() < PHASE_ITEMS) begin
            queue_command();
            if ($urandom_range(0, 7) == 0)
               repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
            ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 15);
            repeat (ticks)
               input_backlog.push_back(stim_type'{ascs_pkg::ACT_TICK,
                                                  8'($urandom_range(0, 255)),
                                                  1'b0, 3'd0, 8'd0});
         end
         run_backlog();
      end

      wait_idle();
      $display("covered %0d items: %0d commands taken, %0d slew steps, %0d register writes",
               items_taken, cmds_taken, slew_steps, csr_writes);
      $display("%0d mismatches in %0d cycles", mismatch_count, cycle_count);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/ascs_pkg.sv
rtl/ascs_parser.sv
rtl/ascii_servo_command_slewer.sv
rtl/ascs_checker.sv
test/ascii_servo_command_slewer_tb.sv
